@@ rtl/ibus_frame_receiver_macros.svh @@
// assertion macros for the ibus frame receiver
// used by ibus_frame_receiver.sv; expects clk and rst_n in the including scope
`ifndef IBUS_FRAME_RECEIVER_MACROS_SVH
`define IBUS_FRAME_RECEIVER_MACROS_SVH

// implication that must hold in the same cycle
`define IFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication that must hold in the next cycle
`define IFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/ifr_pkg.sv @@
// types and constants of the ibus frame receiver
// no dependencies; used by ibus_frame_receiver.sv
package ifr_pkg;

    // frame geometry
    localparam int NUM_CHANNELS  = 14;
    localparam int PAYLOAD_BYTES = 30;
    localparam int CH_W          = $clog2(NUM_CHANNELS);
    localparam int POS_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int WIDX_W        = POS_W - 1;

    // header bytes and fixed values
    localparam logic [7:0]  HDR_FIRST     = 8'h20;
    localparam logic [7:0]  HDR_SECOND    = 8'h40;
    localparam logic [15:0] DEFAULT_VALUE = 16'd1500;
    localparam logic [15:0] SUM_INIT      = 16'hFFFF;
    localparam logic [15:0] SILENCE_MAX   = 16'hFFFF;

    // configuration reset values
    localparam logic [15:0] RST_SILENCE_LIMIT = 16'd100;
    localparam logic [15:0] RST_VALUE_LOW     = 16'd950;
    localparam logic [15:0] RST_VALUE_HIGH    = 16'd2050;

    // configuration register indexes
    localparam logic [1:0] CFG_SILENCE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_VALUE_LOW     = 2'd1;
    localparam logic [1:0] CFG_VALUE_HIGH    = 2'd2;

    // input item modes; the remaining code is ignored
    localparam logic [1:0] MODE_BYTE    = 2'd0;
    localparam logic [1:0] MODE_TICK    = 2'd1;
    localparam logic [1:0] MODE_DEFAULT = 2'd2;

    typedef enum logic [1:0] {
        KIND_FRAME    = 2'd0,
        KIND_FAILSAFE = 2'd1,
        KIND_CSUM_ERR = 2'd2,
        KIND_DEF_ANS  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_HDR1 = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_RUN_RD = 3'd1,
        ST_RUN_WR = 3'd2,
        ST_DEF_RD = 3'd3,
        ST_DEF_WR = 3'd4,
        ST_ERR    = 3'd5
    } state_t;

endpackage

@@ rtl/ibus_frame_receiver.sv @@
// ibus frame receiver: header hunt, checksum check, channel and default stores
// depends on ifr_pkg and ibus_frame_receiver_macros.svh
//
// Usage
//   item channel (item_valid / item_stall): mode selects a received serial byte,
//   a time tick or a channel default write. Only one item is in work at a time;
//   item_stall is high while the sequencer is busy.
//   result channel (result_valid / result_stall): one output register holds the
//   current result; a new item is taken while it waits.
//   cfg channel (cfg_valid / cfg_ready): cfg_ready is always high; write only
//   while the block is idle.
// Result sequences
//   a byte or tick with no result does not stall the item channel.
//   a checksum error passes the error state, then the output register.
//   a default write answer passes a read state (one memory read), a write state, then the register.
//   a good frame or failsafe gives a run of 14 results, each a read, then
//   a modify and write back of the channel store.
// Reset
//   parser hunts for a header, link is dead, all channel values and defaults
//   read as 1500 through per-entry valid bits; no clearing pass.
// Stall
//   while a result waits under result_stall the run holds in place and item_stall stays high.
module ibus_frame_receiver (
    input  logic        clk,
    input  logic        rst_n,
    // item channel
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  mode,
    input  logic [7:0]  rx_byte,
    input  logic [3:0]  default_channel,
    input  logic [15:0] default_value,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [3:0]  channel_index,
    output logic [15:0] channel_value,
    output logic        accepted,
    output logic        link_alive,
    output logic        last,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

`include "ibus_frame_receiver_macros.svh"

    localparam int NCH = ifr_pkg::NUM_CHANNELS;
    localparam int CW  = ifr_pkg::CH_W;
    localparam int PW  = ifr_pkg::POS_W;
    localparam int WW  = ifr_pkg::WIDX_W;

    // memories
    logic [15:0] chan_mem  [NCH];
    logic [15:0] def_mem   [NCH];
    logic [15:0] frame_mem [NCH];

    // control registers
    ifr_pkg::state_t state_reg, state_next;
    ifr_pkg::phase_t phase_reg, phase_next;
    logic [PW-1:0]   pos_reg, pos_next;
    logic [15:0]     sum_reg, sum_next;
    logic            alive_reg, alive_next;
    logic [15:0]     silence_reg, silence_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            fs_reg, fs_next;
    logic            out_vld_reg, out_vld_next;
    logic [NCH-1:0]  chan_vld_reg, chan_vld_next;
    logic [NCH-1:0]  def_vld_reg, def_vld_next;
    logic [15:0]     silence_limit_reg, silence_limit_next;
    logic [15:0]     value_low_reg, value_low_next;
    logic [15:0]     value_high_reg, value_high_next;

    // payload registers
    logic [7:0]      byte_lo_reg, byte_lo_next;
    logic [3:0]      def_ch_reg, def_ch_next;
    logic            def_ok_reg, def_ok_next;
    ifr_pkg::kind_t  kind_reg, kind_next;
    logic [3:0]      index_reg, index_next;
    logic [15:0]     value_reg, value_next;
    logic            acc_reg, acc_next;
    logic            alive_out_reg, alive_out_next;
    logic            last_reg, last_next;
    logic [15:0]     chan_q_reg, def_q_reg, frame_q_reg;
    logic            chan_qv_reg, def_qv_reg;

    // memory strobes
    logic            rd_en;
    logic [CW-1:0]   rd_addr;
    logic            chan_we;
    logic [15:0]     chan_wdata;
    logic            def_we;
    logic [CW-1:0]   def_waddr;
    logic            frame_we;
    logic [CW-1:0]   frame_waddr;

    // helper terms
    logic            item_acc;
    logic            out_free;
    logic [15:0]     chan_rd;
    logic [15:0]     def_rd;
    logic            frame_ok;
    logic [15:0]     new_value;
    logic [WW-1:0]   word_idx;
    logic [15:0]     silence_inc;
    logic            def_in_lim;

    assign item_stall = (state_reg != ifr_pkg::ST_IDLE);
    assign item_acc   = item_valid && !item_stall;
    assign out_free   = !out_vld_reg || !result_stall;
    assign cfg_ready  = 1'b1;

    assign result_valid  = out_vld_reg;
    assign kind          = kind_reg;
    assign channel_index = index_reg;
    assign channel_value = value_reg;
    assign accepted      = acc_reg;
    assign link_alive    = alive_out_reg;
    assign last          = last_reg;

    // read data with reset values for never-written entries
    assign chan_rd = chan_qv_reg ? chan_q_reg : ifr_pkg::DEFAULT_VALUE;
    assign def_rd  = def_qv_reg ? def_q_reg : ifr_pkg::DEFAULT_VALUE;

    // frame word update rule for the current run index
    assign frame_ok = (frame_q_reg >= value_low_reg) && (frame_q_reg <= value_high_reg)
                      && (32'(idx_reg) < (ifr_pkg::PAYLOAD_BYTES - 2) / 2);
    assign new_value = fs_reg ? def_rd : (frame_ok ? frame_q_reg : chan_rd);

    assign word_idx    = pos_reg[PW-1:1];
    assign silence_inc = (silence_reg != ifr_pkg::SILENCE_MAX) ? silence_reg + 16'd1
                                                               : silence_reg;
    assign def_in_lim  = (default_value >= value_low_reg) && (default_value <= value_high_reg);

    // next state, datapath and memory strobes
    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        pos_next           = pos_reg;
        sum_next           = sum_reg;
        alive_next         = alive_reg;
        silence_next       = silence_reg;
        idx_next           = idx_reg;
        fs_next            = fs_reg;
        chan_vld_next      = chan_vld_reg;
        def_vld_next       = def_vld_reg;
        silence_limit_next = silence_limit_reg;
        value_low_next     = value_low_reg;
        value_high_next    = value_high_reg;
        byte_lo_next       = byte_lo_reg;
        def_ch_next        = def_ch_reg;
        def_ok_next        = def_ok_reg;
        kind_next          = kind_reg;
        index_next         = index_reg;
        value_next         = value_reg;
        acc_next           = acc_reg;
        alive_out_next     = alive_out_reg;
        last_next          = last_reg;
        out_vld_next       = out_vld_reg && result_stall;
        rd_en              = 1'b0;
        rd_addr            = idx_reg;
        chan_we            = 1'b0;
        chan_wdata         = new_value;
        def_we             = 1'b0;
        def_waddr          = CW'(default_channel);
        frame_we           = 1'b0;
        frame_waddr        = CW'(word_idx);

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ifr_pkg::CFG_SILENCE_LIMIT: silence_limit_next = cfg_data;
                ifr_pkg::CFG_VALUE_LOW:     value_low_next     = cfg_data;
                ifr_pkg::CFG_VALUE_HIGH:    value_high_next    = cfg_data;
                default:                    ;
            endcase
        end

        unique case (state_reg)
            ifr_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    unique case (mode)
                        ifr_pkg::MODE_BYTE:
                        begin
                            silence_next = '0;
                            unique case (phase_reg)
                                ifr_pkg::PH_HUNT:
                                begin
                                    if (rx_byte == ifr_pkg::HDR_FIRST)
                                    begin
                                        sum_next   = ifr_pkg::SUM_INIT
                                                     - {8'd0, ifr_pkg::HDR_FIRST};
                                        phase_next = ifr_pkg::PH_HDR1;
                                    end
                                end
                                ifr_pkg::PH_HDR1:
                                begin
                                    if (rx_byte == ifr_pkg::HDR_SECOND)
                                    begin
                                        sum_next   = sum_reg - {8'd0, rx_byte};
                                        phase_next = ifr_pkg::PH_DATA;
                                        pos_next   = '0;
                                        alive_next = 1'b1;
                                    end
                                    else if (rx_byte == ifr_pkg::HDR_FIRST)
                                    begin
                                        sum_next = ifr_pkg::SUM_INIT
                                                   - {8'd0, ifr_pkg::HDR_FIRST};
                                    end
                                    else
                                    begin
                                        phase_next = ifr_pkg::PH_HUNT;
                                    end
                                end
                                ifr_pkg::PH_DATA:
                                begin
                                    alive_next = 1'b1;
                                    // low byte held, word written on the high byte
                                    if (!pos_reg[0])
                                    begin
                                        byte_lo_next = rx_byte;
                                    end
                                    else if (word_idx < WW'(NCH)
                                             && pos_reg < PW'(ifr_pkg::PAYLOAD_BYTES - 2))
                                    begin
                                        frame_we = 1'b1;
                                    end
                                    if (pos_reg < PW'(ifr_pkg::PAYLOAD_BYTES - 2))
                                    begin
                                        sum_next = sum_reg - {8'd0, rx_byte};
                                    end
                                    // end of frame: check the checksum word
                                    if (pos_reg == PW'(ifr_pkg::PAYLOAD_BYTES - 1))
                                    begin
                                        pos_next   = '0;
                                        phase_next = ifr_pkg::PH_HUNT;
                                        if ({rx_byte, byte_lo_reg} != sum_reg)
                                        begin
                                            state_next = ifr_pkg::ST_ERR;
                                        end
                                        else
                                        begin
                                            idx_next   = '0;
                                            fs_next    = 1'b0;
                                            state_next = ifr_pkg::ST_RUN_RD;
                                        end
                                    end
                                    else
                                    begin
                                        pos_next = pos_reg + PW'(1);
                                    end
                                end
                                default:
                                begin
                                    phase_next = ifr_pkg::PH_HUNT;
                                    pos_next   = '0;
                                end
                            endcase
                        end
                        ifr_pkg::MODE_TICK:
                        begin
                            silence_next = silence_inc;
                            // failsafe only on the tick that crosses the limit
                            if (silence_reg <= silence_limit_reg
                                && silence_inc > silence_limit_reg)
                            begin
                                alive_next = 1'b0;
                                idx_next   = '0;
                                fs_next    = 1'b1;
                                state_next = ifr_pkg::ST_RUN_RD;
                            end
                        end
                        ifr_pkg::MODE_DEFAULT:
                        begin
                            def_ch_next = default_channel;
                            def_ok_next = 1'b0;
                            if (default_channel != 4'd0 && default_channel < 4'(NCH)
                                && def_in_lim)
                            begin
                                def_we                 = 1'b1;
                                def_vld_next[def_waddr] = 1'b1;
                                def_ok_next            = 1'b1;
                            end
                            state_next = ifr_pkg::ST_DEF_RD;
                        end
                        default: ;
                    endcase
                end
            end
            ifr_pkg::ST_RUN_RD:
            begin
                rd_en      = 1'b1;
                state_next = ifr_pkg::ST_RUN_WR;
            end
            ifr_pkg::ST_RUN_WR:
            begin
                // modify and write back once the output register is free
                if (out_free)
                begin
                    chan_we                = 1'b1;
                    chan_vld_next[idx_reg] = 1'b1;
                    out_vld_next           = 1'b1;
                    kind_next              = fs_reg ? ifr_pkg::KIND_FAILSAFE
                                                    : ifr_pkg::KIND_FRAME;
                    index_next             = 4'(idx_reg);
                    value_next             = new_value;
                    acc_next               = 1'b0;
                    alive_out_next         = alive_reg;
                    last_next              = (idx_reg == CW'(NCH - 1));
                    if (idx_reg == CW'(NCH - 1))
                    begin
                        state_next = ifr_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = ifr_pkg::ST_RUN_RD;
                    end
                end
            end
            ifr_pkg::ST_DEF_RD:
            begin
                rd_addr    = CW'(def_ch_reg);
                rd_en      = (def_ch_reg < 4'(NCH));
                state_next = ifr_pkg::ST_DEF_WR;
            end
            ifr_pkg::ST_DEF_WR:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    kind_next      = ifr_pkg::KIND_DEF_ANS;
                    index_next     = def_ch_reg;
                    value_next     = (def_ch_reg < 4'(NCH)) ? def_rd : 16'd0;
                    acc_next       = def_ok_reg;
                    alive_out_next = alive_reg;
                    last_next      = 1'b1;
                    state_next     = ifr_pkg::ST_IDLE;
                end
            end
            ifr_pkg::ST_ERR:
            begin
                if (out_free)
                begin
                    out_vld_next   = 1'b1;
                    kind_next      = ifr_pkg::KIND_CSUM_ERR;
                    index_next     = 4'd0;
                    value_next     = 16'd0;
                    acc_next       = 1'b0;
                    alive_out_next = alive_reg;
                    last_next      = 1'b1;
                    state_next     = ifr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ifr_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ifr_pkg::ST_IDLE;
            phase_reg         <= ifr_pkg::PH_HUNT;
            pos_reg           <= '0;
            sum_reg           <= ifr_pkg::SUM_INIT;
            alive_reg         <= 1'b0;
            silence_reg       <= '0;
            idx_reg           <= '0;
            fs_reg            <= 1'b0;
            out_vld_reg       <= 1'b0;
            chan_vld_reg      <= '0;
            def_vld_reg       <= '0;
            silence_limit_reg <= ifr_pkg::RST_SILENCE_LIMIT;
            value_low_reg     <= ifr_pkg::RST_VALUE_LOW;
            value_high_reg    <= ifr_pkg::RST_VALUE_HIGH;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            pos_reg           <= pos_next;
            sum_reg           <= sum_next;
            alive_reg         <= alive_next;
            silence_reg       <= silence_next;
            idx_reg           <= idx_next;
            fs_reg            <= fs_next;
            out_vld_reg       <= out_vld_next;
            chan_vld_reg      <= chan_vld_next;
            def_vld_reg       <= def_vld_next;
            silence_limit_reg <= silence_limit_next;
            value_low_reg     <= value_low_next;
            value_high_reg    <= value_high_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        byte_lo_reg   <= byte_lo_next;
        def_ch_reg    <= def_ch_next;
        def_ok_reg    <= def_ok_next;
        kind_reg      <= kind_next;
        index_reg     <= index_next;
        value_reg     <= value_next;
        acc_reg       <= acc_next;
        alive_out_reg <= alive_out_next;
        last_reg      <= last_next;
    end

    // memories: one registered read port, one write port each
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            chan_q_reg  <= chan_mem[rd_addr];
            def_q_reg   <= def_mem[rd_addr];
            frame_q_reg <= frame_mem[rd_addr];
            chan_qv_reg <= chan_vld_reg[rd_addr];
            def_qv_reg  <= def_vld_reg[rd_addr];
        end
        if (chan_we)
        begin
            chan_mem[idx_reg] <= chan_wdata;
        end
        if (def_we)
        begin
            def_mem[def_waddr] <= default_value;
        end
        if (frame_we)
        begin
            frame_mem[frame_waddr] <= {rx_byte, byte_lo_reg};
        end
    end

    // checks
    `IFR_ASSERT_NOW(a_frame_alive,
        result_valid && kind == ifr_pkg::KIND_FRAME, link_alive,
        "frame run reported with link down")
    `IFR_ASSERT_NOW(a_failsafe_dead,
        result_valid && kind == ifr_pkg::KIND_FAILSAFE, !link_alive,
        "failsafe run reported with link alive")
    `IFR_ASSERT_NOW(a_accept_kind,
        result_valid && accepted, kind == ifr_pkg::KIND_DEF_ANS,
        "accepted flag outside a default answer")
    `IFR_ASSERT_NOW(a_err_fields,
        result_valid && kind == ifr_pkg::KIND_CSUM_ERR, last && channel_value == 16'd0,
        "checksum error result malformed")
    `IFR_ASSERT_NEXT(a_run_step,
        state_reg == ifr_pkg::ST_RUN_RD, state_reg == ifr_pkg::ST_RUN_WR,
        "run read not followed by write back")

endmodule
